// ===== hw/rtl/fixed_sincos_taylor_assert.svh =====
// Assertion macros for the fixed-point sine and cosine block.
`ifndef FIXED_SINCOS_TAYLOR_ASSERT_SVH
`define FIXED_SINCOS_TAYLOR_ASSERT_SVH

// Condition must never hold outside reset.
`define FXSC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fxsc: forbidden condition seen");

// Antecedent in the same cycle implies the consequent.
`define FXSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fxsc: implication failed");

// Antecedent implies the consequent a fixed number of cycles later.
`define FXSC_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ## (n) (cons)) \
        else $error("fxsc: delayed implication failed");

`endif

// ===== hw/rtl/fxsc_pkg.sv =====
// Shared widths, coefficients and types of the fixed-point sine and cosine block.
package fxsc_pkg;

    localparam int PhaseW  = 20;
    localparam int QW      = 18;
    localparam int PW      = 2 * QW;
    localparam int SW      = 21;
    localparam int OutW    = 18;
    localparam int Latency = 7;

    localparam logic [QW-1:0] K_S1 = 18'd205887;
    localparam logic [QW-1:0] K_S3 = 18'd169336;
    localparam logic [QW-1:0] K_S5 = 18'd167014;
    localparam logic [QW-1:0] K_S7 = 18'd150000;
    localparam logic [QW-1:0] K_C2 = 18'd161704;
    localparam logic [QW-1:0] K_C4 = 18'd132996;
    localparam logic [QW-1:0] K_C6 = 18'd175016;
    localparam logic [QW-1:0] K_C8 = 18'd241700;

    localparam logic signed [SW-1:0] ONE_Q18 = 21'sd262144;
    localparam logic signed [SW-1:0] ONE_Q17 = 21'sd131072;
    localparam logic signed [SW-1:0] OUT_MAX = 21'sd131071;
    localparam logic signed [SW-1:0] OUT_MIN = -21'sd131072;

    typedef struct packed {
        logic quad_lo;
        logic quad_hi;
        logic quarter_pt;
    } t_flags;

    function automatic logic [PW-1:0] mul_q(input logic [QW-1:0] a, input logic [QW-1:0] b);
        mul_q = PW'(a) * PW'(b);
    endfunction

endpackage

// ===== hw/rtl/fxsc_fold.sv =====
// Quadrant decode and reflection of the phase into the first quarter turn.
module fxsc_fold (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fxsc_pkg::PhaseW-1:0]  i_phase,
    output logic                         o_valid,
    output logic [fxsc_pkg::QW-1:0]      o_x1,
    output fxsc_pkg::t_flags             o_flags
);

    logic [fxsc_pkg::QW-1:0] w_low;
    logic [fxsc_pkg::QW-1:0] n_x1;
    fxsc_pkg::t_flags        n_flags;

    logic                    r_valid;
    logic [fxsc_pkg::QW-1:0] r_x1;
    fxsc_pkg::t_flags        r_flags;

    always_comb begin
        w_low              = i_phase[fxsc_pkg::QW-1:0];
        n_flags.quad_lo    = i_phase[fxsc_pkg::QW];
        n_flags.quad_hi    = i_phase[fxsc_pkg::QW+1];
        n_flags.quarter_pt = n_flags.quad_lo && (w_low == '0);
        // reflect in odd quadrants
        n_x1 = n_flags.quad_lo ? (fxsc_pkg::QW'(0) - w_low) : w_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= n_x1;
        r_flags <= n_flags;
    end

    assign o_valid = r_valid;
    assign o_x1    = r_x1;
    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/fxsc_terms.sv =====
// Power and Taylor term pipeline: five multiply stages that build both series sums.
module fxsc_terms (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [fxsc_pkg::QW-1:0]           i_x1,
    input  fxsc_pkg::t_flags                  i_flags,
    output logic                              o_valid,
    output logic signed [fxsc_pkg::SW-1:0]    o_sin_sum,
    output logic signed [fxsc_pkg::SW-1:0]    o_cos_sum,
    output fxsc_pkg::t_flags                  o_flags
);

    localparam int QW = fxsc_pkg::QW;
    localparam int PW = fxsc_pkg::PW;
    localparam int SW = fxsc_pkg::SW;

    logic [4:0]       r_valid;
    fxsc_pkg::t_flags r_flags [5];

    // stage 2
    logic [QW-1:0] r_s2_x1, r_s2_x2;
    logic [QW:0]   r_s2_t1;
    // stage 3
    logic [QW-1:0] r_s3_x2, r_s3_x3, r_s3_x4;
    logic [QW:0]   r_s3_t1, r_s3_t2;
    // stage 4
    logic [QW-1:0]        r_s4_x2, r_s4_x5, r_s4_x6, r_s4_x8;
    logic signed [SW-1:0] r_s4_s, r_s4_c;
    // stage 5
    logic [QW-1:0]        r_s5_x7;
    logic signed [SW-1:0] r_s5_s, r_s5_c;
    // stage 6
    logic signed [SW-1:0] r_s6_s, r_s6_c;

    logic [PW-1:0] w_p11, w_pk1, w_p21, w_p22, w_pk2;
    logic [PW-1:0] w_p23, w_p42, w_p44, w_pk3, w_pk4;
    logic [PW-1:0] w_p25, w_pk5, w_pk6, w_pk8, w_pk7;

    logic signed [SW-1:0] n_s4_s, n_s4_c, n_s5_s, n_s5_c, n_s6_s;

    always_comb begin
        w_p11 = fxsc_pkg::mul_q(i_x1, i_x1);
        w_pk1 = fxsc_pkg::mul_q(fxsc_pkg::K_S1, i_x1);
        w_p21 = fxsc_pkg::mul_q(r_s2_x2, r_s2_x1);
        w_p22 = fxsc_pkg::mul_q(r_s2_x2, r_s2_x2);
        w_pk2 = fxsc_pkg::mul_q(fxsc_pkg::K_C2, r_s2_x2);
        w_p23 = fxsc_pkg::mul_q(r_s3_x2, r_s3_x3);
        w_p42 = fxsc_pkg::mul_q(r_s3_x4, r_s3_x2);
        w_p44 = fxsc_pkg::mul_q(r_s3_x4, r_s3_x4);
        w_pk3 = fxsc_pkg::mul_q(fxsc_pkg::K_S3, r_s3_x3);
        w_pk4 = fxsc_pkg::mul_q(fxsc_pkg::K_C4, r_s3_x4);
        w_p25 = fxsc_pkg::mul_q(r_s4_x2, r_s4_x5);
        w_pk5 = fxsc_pkg::mul_q(fxsc_pkg::K_S5, r_s4_x5);
        w_pk6 = fxsc_pkg::mul_q(fxsc_pkg::K_C6, r_s4_x6);
        w_pk8 = fxsc_pkg::mul_q(fxsc_pkg::K_C8, r_s4_x8);
        w_pk7 = fxsc_pkg::mul_q(fxsc_pkg::K_S7, r_s5_x7);

        n_s4_s = $signed({2'b00, r_s3_t1}) - $signed({3'b000, w_pk3[PW-1:18]});
        n_s4_c = fxsc_pkg::ONE_Q18 - $signed({2'b00, r_s3_t2})
               + $signed({4'b0000, w_pk4[PW-1:19]});
        n_s5_s = r_s4_s + $signed({6'b000000, w_pk5[PW-1:21]});
        n_s5_c = r_s4_c - $signed({8'b00000000, w_pk6[PW-1:23]})
               + $signed({13'b0000000000000, w_pk8[PW-1:28]});
        n_s6_s = r_s5_s - $signed({10'b0000000000, w_pk7[PW-1:25]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_flags;
        for (int i = 1; i < 5; i++) begin
            r_flags[i] <= r_flags[i-1];
        end

        r_s2_x1 <= i_x1;
        r_s2_x2 <= w_p11[PW-1:QW];
        r_s2_t1 <= w_pk1[PW-1:17];

        r_s3_x2 <= r_s2_x2;
        r_s3_x3 <= w_p21[PW-1:QW];
        r_s3_x4 <= w_p22[PW-1:QW];
        r_s3_t1 <= r_s2_t1;
        r_s3_t2 <= w_pk2[PW-1:17];

        r_s4_x2 <= r_s3_x2;
        r_s4_x5 <= w_p23[PW-1:QW];
        r_s4_x6 <= w_p42[PW-1:QW];
        r_s4_x8 <= w_p44[PW-1:QW];
        r_s4_s  <= n_s4_s;
        r_s4_c  <= n_s4_c;

        r_s5_x7 <= w_p25[PW-1:QW];
        r_s5_s  <= n_s5_s;
        r_s5_c  <= n_s5_c;

        r_s6_s  <= n_s6_s;
        r_s6_c  <= r_s5_c;
    end

    assign o_valid   = r_valid[4];
    assign o_sin_sum = r_s6_s;
    assign o_cos_sum = r_s6_c;
    assign o_flags   = r_flags[4];

endmodule

// ===== hw/rtl/fxsc_finish.sv =====
// Output stage: halving, quarter-point override, quadrant sign and saturation.
module fxsc_finish (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [fxsc_pkg::SW-1:0]     i_sin_sum,
    input  logic signed [fxsc_pkg::SW-1:0]     i_cos_sum,
    input  fxsc_pkg::t_flags                   i_flags,
    output logic                               o_valid,
    output logic signed [fxsc_pkg::OutW-1:0]   o_sine,
    output logic signed [fxsc_pkg::OutW-1:0]   o_cosine
);

    localparam int SW   = fxsc_pkg::SW;
    localparam int OutW = fxsc_pkg::OutW;

    logic signed [SW-1:0]   w_s, w_c;
    logic signed [OutW-1:0] n_sine, n_cosine;

    logic                   r_valid;
    logic signed [OutW-1:0] r_sine, r_cosine;

    function automatic logic signed [OutW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > fxsc_pkg::OUT_MAX) begin
            sat = fxsc_pkg::OUT_MAX[OutW-1:0];
        end else if (v < fxsc_pkg::OUT_MIN) begin
            sat = fxsc_pkg::OUT_MIN[OutW-1:0];
        end else begin
            sat = v[OutW-1:0];
        end
    endfunction

    always_comb begin
        w_s = i_sin_sum >>> 1;
        w_c = i_cos_sum >>> 1;
        if (i_flags.quarter_pt) begin
            w_s = fxsc_pkg::ONE_Q17;
            w_c = '0;
        end
        if (i_flags.quad_hi) begin
            w_s = -w_s;
        end
        if (i_flags.quad_lo != i_flags.quad_hi) begin
            w_c = -w_c;
        end
        n_sine   = sat(w_s);
        n_cosine = sat(w_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine   <= n_sine;
        r_cosine <= n_cosine;
    end

    assign o_valid  = r_valid;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

endmodule

// ===== hw/rtl/fixed_sincos_taylor.sv =====
// Top level of the fixed-point sine and cosine block.
// Takes one 20-bit phase per clock (one turn is 2^20) and returns sine and cosine
// in 18-bit two's complement scaled by 2^17. busy is always low, so a phase can be
// started in every cycle. Each result appears on o_sine_out and o_cosine_out for
// one cycle with o_valid high, after the fold, the five multiply stages and the
// output stage, in start order; the receiver must take it then. The depth is set
// by the chain of dependent 18x18 multiplies that builds x^7.
module fixed_sincos_taylor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fxsc_pkg::PhaseW-1:0]         i_phase,
    output logic                                o_valid,
    output logic signed [fxsc_pkg::OutW-1:0]    o_sine_out,
    output logic signed [fxsc_pkg::OutW-1:0]    o_cosine_out
);

    logic                           w_fold_valid;
    logic [fxsc_pkg::QW-1:0]        w_x1;
    fxsc_pkg::t_flags               w_fold_flags;
    logic                           w_terms_valid;
    logic signed [fxsc_pkg::SW-1:0] w_sin_sum, w_cos_sum;
    fxsc_pkg::t_flags               w_terms_flags;

    assign busy = 1'b0;

    fxsc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_phase (i_phase),
        .o_valid (w_fold_valid),
        .o_x1    (w_x1),
        .o_flags (w_fold_flags)
    );

    fxsc_terms u_terms (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_fold_valid),
        .i_x1      (w_x1),
        .i_flags   (w_fold_flags),
        .o_valid   (w_terms_valid),
        .o_sin_sum (w_sin_sum),
        .o_cos_sum (w_cos_sum),
        .o_flags   (w_terms_flags)
    );

    fxsc_finish u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_terms_valid),
        .i_sin_sum (w_sin_sum),
        .i_cos_sum (w_cos_sum),
        .i_flags   (w_terms_flags),
        .o_valid   (o_valid),
        .o_sine    (o_sine_out),
        .o_cosine  (o_cosine_out)
    );

endmodule

// ===== hw/rtl/fxsc_check.sv =====
// Port-level assertion checker for the fixed-point sine and cosine block, with its bind.
`include "fixed_sincos_taylor_assert.svh"

module fxsc_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [fxsc_pkg::PhaseW-1:0]       i_phase,
    input logic                              o_valid,
    input logic signed [fxsc_pkg::OutW-1:0]  o_sine_out,
    input logic signed [fxsc_pkg::OutW-1:0]  o_cosine_out
);

    localparam int Latency = fxsc_pkg::Latency;

    logic w_xfer_in;
    logic w_quarter_in;
    logic w_zero_in;

    assign w_xfer_in    = start && !busy;
    assign w_quarter_in = w_xfer_in && i_phase[18] && (i_phase[17:0] == '0);
    assign w_zero_in    = w_xfer_in && (i_phase[18:0] == '0);

    `FXSC_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)
    `FXSC_ASSERT_DELAY(a_transfer_out, i_clk, i_rst_n, w_xfer_in, Latency, o_valid)
    `FXSC_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, o_valid, $past(w_xfer_in, Latency))
    `FXSC_ASSERT_DELAY(a_quarter_cos, i_clk, i_rst_n, w_quarter_in, Latency, o_cosine_out == 0)
    `FXSC_ASSERT_DELAY(a_zero_sin, i_clk, i_rst_n, w_zero_in, Latency, o_sine_out == 0)

endmodule

bind fixed_sincos_taylor fxsc_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_phase      (i_phase),
    .o_valid      (o_valid),
    .o_sine_out   (o_sine_out),
    .o_cosine_out (o_cosine_out)
);
